FILE: design/assert_macros.svh
// Assertion helpers included by the controller core.
// Every check is clocked on aclk and held off while aresetn is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property check with a message.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Same-cycle implication check.
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`endif

FILE: design/hamc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hamc_pkg: shared types and constants for the headphone auto-mute controller
// Register map, startup modes and button width.
// ----------------------------------------------------------------------------
package hamc_pkg;

    localparam int BUTTON_BITS = 32;
    localparam int BTN_W       = 32;
    localparam int ADDR_W      = 5;
    localparam int DATA_W      = 32;

    localparam logic [BTN_W-1:0] BUTTON_MASK =
        (BUTTON_BITS >= BTN_W) ? {BTN_W{1'b1}}
                               : BTN_W'((64'd1 << BUTTON_BITS) - 64'd1);

    typedef enum logic [1:0] {
        MODE_OFF    = 2'd0,
        MODE_ON     = 2'd1,
        MODE_DETECT = 2'd2
    } startup_mode_t;

    typedef enum logic [2:0] {
        REG_STARTUP_MODE   = 3'd0,
        REG_TOGGLE_MASK    = 3'd1,
        REG_NOTIFY_ENABLE  = 3'd2,
        REG_AUTO_PLUGGED   = 3'd3,
        REG_RESUME_WATCH   = 3'd4,
        REG_RESUME_DISABLE = 3'd5
    } reg_index_t;

    // Resume status: bit 0 resuming, bit 1 resume complete.
    typedef struct packed {
        logic done;
        logic resuming;
    } power_status_t;

endpackage : hamc_pkg
`default_nettype wire

FILE: design/headphone_auto_mute_controller_core.sv
// A transfer accepted on s_* passes the input register, then the result register, to m_*.
// Throughput: one tick item per cycle through both registers unless m_ready stalls.
// The controller state updates in the same cycle the item moves into the result register.
// Reset (synchronous, aresetn low): pipeline empty, state cleared, startup_mode 2, others 0.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// headphone_auto_mute_controller_core
// Per-tick headphone plug tracking, chord toggle, resume handling and
// speaker auto-mute, behind an input register and a result register.
// ----------------------------------------------------------------------------
module headphone_auto_mute_controller_core (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    // configuration
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [hamc_pkg::ADDR_W-1:0] paddr,
    input  wire logic [hamc_pkg::DATA_W-1:0] pwdata,
    output logic      [hamc_pkg::DATA_W-1:0] prdata,
    output logic                            pready,
    // tick input
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire logic [hamc_pkg::BTN_W-1:0] s_buttons,
    input  wire logic                       s_headphone_present,
    input  wire logic                       s_current_muted,
    input  wire logic                       s_power_event_valid,
    input  wire logic                       s_power_resuming,
    input  wire logic                       s_power_resume_done,
    // result
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic                            m_mute_write,
    output logic                            m_mute_value,
    output logic                            m_is_active,
    output logic                            m_notify_enabled,
    output logic                            m_notify_disabled,
    output logic                            m_notify_muted,
    output logic                            m_notify_clear,
    output logic                            m_settle_delay
);
    import hamc_pkg::*;

    // configuration registers
    logic [1:0]       startup_mode_reg;
    logic [BTN_W-1:0] toggle_mask_reg;
    logic             notify_enable_reg;
    logic             auto_plugged_reg;
    logic             resume_watch_reg;
    logic             resume_disable_reg;

    // controller state
    logic          started_reg,  started_next;
    logic          active_reg,   active_next;
    logic          wait_rel_reg, wait_rel_next;
    logic          phones_reg,   phones_next;
    logic          muted_by_reg, muted_by_next;
    power_status_t held_reg,     held_next;

    // input register
    logic             in_valid_reg;
    logic [BTN_W-1:0] in_buttons_reg;
    logic             in_present_reg;
    logic             in_cur_muted_reg;
    logic             in_ev_valid_reg;
    logic             in_resuming_reg;
    logic             in_done_reg;

    // result register
    logic m_valid_reg;
    logic m_mute_write_reg,  m_mute_write_next;
    logic m_mute_value_reg,  m_mute_value_next;
    logic m_is_active_reg;
    logic m_n_en_reg,        m_n_en_next;
    logic m_n_dis_reg,       m_n_dis_next;
    logic m_n_mut_reg,       m_n_mut_next;
    logic m_n_clr_reg,       m_n_clr_next;
    logic m_settle_reg,      m_settle_next;

    logic       advance;
    logic       cfg_write;
    reg_index_t cfg_index;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_index = reg_index_t'(paddr[ADDR_W-1:2]);

    assign advance = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    // ------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            startup_mode_reg   <= MODE_DETECT;
            toggle_mask_reg    <= '0;
            notify_enable_reg  <= 1'b0;
            auto_plugged_reg   <= 1'b0;
            resume_watch_reg   <= 1'b0;
            resume_disable_reg <= 1'b0;
        end else if (cfg_write) begin
            unique case (cfg_index)
                REG_STARTUP_MODE:   startup_mode_reg   <= pwdata[1:0];
                REG_TOGGLE_MASK:    toggle_mask_reg    <= pwdata[BTN_W-1:0];
                REG_NOTIFY_ENABLE:  notify_enable_reg  <= pwdata[0];
                REG_AUTO_PLUGGED:   auto_plugged_reg   <= pwdata[0];
                REG_RESUME_WATCH:   resume_watch_reg   <= pwdata[0];
                REG_RESUME_DISABLE: resume_disable_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (cfg_index)
            REG_STARTUP_MODE:   prdata[1:0]       = startup_mode_reg;
            REG_TOGGLE_MASK:    prdata[BTN_W-1:0] = toggle_mask_reg;
            REG_NOTIFY_ENABLE:  prdata[0]         = notify_enable_reg;
            REG_AUTO_PLUGGED:   prdata[0]         = auto_plugged_reg;
            REG_RESUME_WATCH:   prdata[0]         = resume_watch_reg;
            REG_RESUME_DISABLE: prdata[0]         = resume_disable_reg;
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // input register
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_buttons_reg   <= s_buttons;
            in_present_reg   <= s_headphone_present;
            in_cur_muted_reg <= s_current_muted;
            in_ev_valid_reg  <= s_power_event_valid;
            in_resuming_reg  <= s_power_resuming;
            in_done_reg      <= s_power_resume_done;
        end
    end

    // ------------------------------------------------------------------
    // tick evaluation
    // ------------------------------------------------------------------
    always_comb begin
        logic [BTN_W-1:0] btn;
        logic [BTN_W-1:0] tmask;
        logic             present;
        logic             plug_in;
        logic             plug_out;
        logic             skip;

        btn      = in_buttons_reg & BUTTON_MASK;
        tmask    = toggle_mask_reg & BUTTON_MASK;
        present  = in_present_reg;
        plug_in  = 1'b0;
        plug_out = 1'b0;
        skip     = 1'b0;

        started_next      = started_reg;
        active_next       = active_reg;
        wait_rel_next     = wait_rel_reg;
        phones_next       = phones_reg;
        muted_by_next     = muted_by_reg;
        held_next         = held_reg;
        m_mute_write_next = 1'b0;
        m_mute_value_next = 1'b0;
        m_n_en_next       = 1'b0;
        m_n_dis_next      = 1'b0;
        m_n_mut_next      = 1'b0;
        m_n_clr_next      = 1'b0;
        m_settle_next     = 1'b0;

        // latch a fresh power status
        if (resume_watch_reg && in_ev_valid_reg) begin
            held_next.resuming = in_resuming_reg;
            held_next.done     = in_done_reg;
        end

        // startup mode on the first tick
        if (!started_reg) begin
            started_next = 1'b1;
            case (startup_mode_reg)
                MODE_DETECT: begin
                    if (present) begin
                        active_next = 1'b1;
                        phones_next = 1'b1;
                        m_n_en_next = 1'b1;
                    end
                end
                MODE_ON: begin
                    active_next = 1'b1;
                    phones_next = present;
                    m_n_en_next = 1'b1;
                end
                default: ;
            endcase
        end

        // plug edges
        plug_in     = present && !phones_next;
        plug_out    = !present && phones_next;
        phones_next = present;

        if (held_next.done || held_next.resuming) begin
            if (held_next.done) begin
                held_next = '0;
                if (!active_next && present) begin
                    active_next = 1'b1;
                    m_n_en_next = 1'b1;
                end else if (resume_disable_reg && active_next && !present) begin
                    active_next  = 1'b0;
                    m_n_dis_next = 1'b1;
                    plug_out     = 1'b1;
                end
            end else begin
                skip = 1'b1;
            end
        end else if ((btn & tmask) == tmask) begin
            if (!wait_rel_reg) begin
                wait_rel_next = 1'b1;
                if (!active_next) begin
                    active_next = 1'b1;
                    m_n_en_next = 1'b1;
                end else begin
                    active_next  = 1'b0;
                    m_n_dis_next = 1'b1;
                    if (!present) begin
                        plug_out = 1'b1;
                    end
                end
            end
        end else begin
            wait_rel_next = 1'b0;
        end

        if (!skip) begin
            if (active_next) begin
                if (!present) begin
                    if (!in_cur_muted_reg) begin
                        m_mute_write_next = 1'b1;
                        m_mute_value_next = 1'b1;
                        muted_by_next     = 1'b1;
                    end
                    m_n_mut_next = notify_enable_reg;
                end else if (plug_in) begin
                    m_settle_next = 1'b1;
                    // restore only what this block muted
                    if (muted_by_next) begin
                        m_mute_write_next = 1'b1;
                    end
                    muted_by_next = 1'b0;
                    m_n_clr_next  = notify_enable_reg;
                end
            end else begin
                if (present) begin
                    if (auto_plugged_reg) begin
                        active_next = 1'b1;
                        m_n_en_next = 1'b1;
                    end
                end else if (plug_out) begin
                    if (muted_by_next) begin
                        m_mute_write_next = 1'b1;
                    end
                    muted_by_next = 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // state and result registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            started_reg  <= 1'b0;
            active_reg   <= 1'b0;
            wait_rel_reg <= 1'b0;
            phones_reg   <= 1'b0;
            muted_by_reg <= 1'b0;
            held_reg     <= '0;
        end else if (advance) begin
            started_reg  <= started_next;
            active_reg   <= active_next;
            wait_rel_reg <= wait_rel_next;
            phones_reg   <= phones_next;
            muted_by_reg <= muted_by_next;
            held_reg     <= held_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_mute_write_reg <= m_mute_write_next;
            m_mute_value_reg <= m_mute_value_next;
            m_is_active_reg  <= active_next;
            m_n_en_reg       <= m_n_en_next;
            m_n_dis_reg      <= m_n_dis_next;
            m_n_mut_reg      <= m_n_mut_next;
            m_n_clr_reg      <= m_n_clr_next;
            m_settle_reg     <= m_settle_next;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_mute_write      = m_mute_write_reg;
    assign m_mute_value      = m_mute_value_reg;
    assign m_is_active       = m_is_active_reg;
    assign m_notify_enabled  = m_n_en_reg;
    assign m_notify_disabled = m_n_dis_reg;
    assign m_notify_muted    = m_n_mut_reg;
    assign m_notify_clear    = m_n_clr_reg;
    assign m_settle_delay    = m_settle_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    `ASSERT_IMPLY(a_settle_unmutes, m_valid_reg && m_settle_reg,
        m_is_active_reg && !m_mute_value_reg, "settle delay without active unmute path")
    `ASSERT_IMPLY(a_muted_note_active, m_valid_reg && m_n_mut_reg,
        m_is_active_reg && notify_enable_reg, "muted notification while inactive")
    `ASSERT_IMPLY(a_stall_only_when_full, !s_ready,
        in_valid_reg && m_valid_reg && !m_ready, "input stalled with room downstream")
    `ASSERT_CLK(a_started_sticks, started_reg |=> started_reg, "started flag dropped")
    `ASSERT_IMPLY(a_value_needs_write, m_valid_reg && m_mute_value_reg,
        m_mute_write_reg, "mute value set without a write")

endmodule : headphone_auto_mute_controller_core
`default_nettype wire

FILE: tb/headphone_auto_mute_controller_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// headphone_auto_mute_controller_core_tb
// Self-checking bench for the headphone auto-mute core. Poll ticks go in over
// a valid/ready channel, settings over the APB port; an in-bench predictor of
// the controller state computes each tick's mute action, and every result
// transfer is compared field by field against it, in order.
// ----------------------------------------------------------------------------
module headphone_auto_mute_controller_core_tb;
    import hamc_pkg::*;

    localparam int NUM_REGS = int'(REG_RESUME_DISABLE) + 1;
    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int STALL_LIMIT = 4000;
    localparam int HOLD_OFF_CYCLES = 300;

    typedef struct packed {
        logic [BTN_W-1:0] buttons;
        logic             present;
        logic             cur_muted;
        logic             power_valid;
        logic             resuming;
        logic             resume_done;
    } tick_t;

    typedef struct packed {
        logic mute_write;
        logic mute_value;
        logic is_active;
        logic notify_enabled;
        logic notify_disabled;
        logic notify_muted;
        logic notify_clear;
        logic settle_delay;
    } mute_result_t;

    // indexed by bit position inside mute_result_t
    string result_field [8] = '{"settle_delay", "notify_clear", "notify_muted",
                                "notify_disabled", "notify_enabled", "is_active",
                                "mute_value", "mute_write"};

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [ADDR_W-1:0]   paddr = '0;
    logic [DATA_W-1:0]   pwdata = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic [BTN_W-1:0]    s_buttons = '0;
    logic                s_headphone_present = 1'b0;
    logic                s_current_muted = 1'b0;
    logic                s_power_event_valid = 1'b0;
    logic                s_power_resuming = 1'b0;
    logic                s_power_resume_done = 1'b0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic                m_mute_write;
    logic                m_mute_value;
    logic                m_is_active;
    logic                m_notify_enabled;
    logic                m_notify_disabled;
    logic                m_notify_muted;
    logic                m_notify_clear;
    logic                m_settle_delay;

    // predictor copy of the registers and controller state
    logic [31:0]         reg_file [NUM_REGS] = '{default: '0};
    bit                  started = 1'b0;
    bit                  active_flag = 1'b0;
    bit                  wait_release = 1'b0;
    bit                  phones_seen = 1'b0;
    bit                  muted_by_us = 1'b0;
    power_status_t       held = '0;

    mute_result_t        expected_actions [$];
    bit                  speaker_muted = 1'b0;
    bit                  steady = 1'b0;
    bit                  hold_req = 1'b0;
    int                  hold_left = 0;
    int                  error_count = 0;
    int                  ticks_sent = 0;
    int                  results_checked = 0;
    int                  settings_loaded = 0;

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    headphone_auto_mute_controller_core dut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .psel                (psel),
        .penable             (penable),
        .pwrite              (pwrite),
        .paddr               (paddr),
        .pwdata              (pwdata),
        .prdata              (prdata),
        .pready              (pready),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_buttons           (s_buttons),
        .s_headphone_present (s_headphone_present),
        .s_current_muted     (s_current_muted),
        .s_power_event_valid (s_power_event_valid),
        .s_power_resuming    (s_power_resuming),
        .s_power_resume_done (s_power_resume_done),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_mute_write        (m_mute_write),
        .m_mute_value        (m_mute_value),
        .m_is_active         (m_is_active),
        .m_notify_enabled    (m_notify_enabled),
        .m_notify_disabled   (m_notify_disabled),
        .m_notify_muted      (m_notify_muted),
        .m_notify_clear      (m_notify_clear),
        .m_settle_delay      (m_settle_delay)
    );

    function automatic mute_result_t predict_mute_action(tick_t t);
        mute_result_t     r;
        logic [BTN_W-1:0] pressed;
        logic [BTN_W-1:0] chord;
        bit               plug_in;
        bit               plug_out;
        bit               frozen;
        r = '0;
        frozen = 1'b0;
        pressed = t.buttons & BUTTON_MASK;
        chord = reg_file[REG_TOGGLE_MASK][BTN_W-1:0] & BUTTON_MASK;
        if (reg_file[REG_RESUME_WATCH][0] && t.power_valid) begin
            held.resuming = t.resuming;
            held.done = t.resume_done;
        end
        // startup mode counts on the very first tick only; the unused code acts as off
        if (!started) begin
            started = 1'b1;
            if (reg_file[REG_STARTUP_MODE][1:0] == MODE_DETECT) begin
                if (t.present) begin
                    active_flag = 1'b1;
                    phones_seen = 1'b1;
                    r.notify_enabled = 1'b1;
                end
            end else if (reg_file[REG_STARTUP_MODE][1:0] == MODE_ON) begin
                active_flag = 1'b1;
                phones_seen = t.present;
                r.notify_enabled = 1'b1;
            end
        end
        plug_in = t.present && !phones_seen;
        plug_out = !t.present && phones_seen;
        phones_seen = t.present;
        if (held != '0) begin
            if (held.done) begin
                held = '0;
                if (!active_flag && t.present) begin
                    active_flag = 1'b1;
                    r.notify_enabled = 1'b1;
                end else if (reg_file[REG_RESUME_DISABLE][0] && active_flag && !t.present) begin
                    active_flag = 1'b0;
                    r.notify_disabled = 1'b1;
                    plug_out = 1'b1;
                end
            end else begin
                // resume still in progress: no toggle, no mute action
                frozen = 1'b1;
            end
        end else if ((pressed & chord) == chord) begin
            if (!wait_release) begin
                wait_release = 1'b1;
                if (!active_flag) begin
                    active_flag = 1'b1;
                    r.notify_enabled = 1'b1;
                end else begin
                    active_flag = 1'b0;
                    r.notify_disabled = 1'b1;
                    plug_out = plug_out || !t.present;
                end
            end
        end else begin
            wait_release = 1'b0;
        end
        if (!frozen) begin
            if (active_flag) begin
                if (!t.present) begin
                    if (!t.cur_muted) begin
                        r.mute_write = 1'b1;
                        r.mute_value = 1'b1;
                        muted_by_us = 1'b1;
                    end
                    r.notify_muted = reg_file[REG_NOTIFY_ENABLE][0];
                end else if (plug_in) begin
                    r.settle_delay = 1'b1;
                    // unmute only what we muted ourselves
                    if (muted_by_us)
                        r.mute_write = 1'b1;
                    muted_by_us = 1'b0;
                    r.notify_clear = reg_file[REG_NOTIFY_ENABLE][0];
                end
            end else if (t.present) begin
                if (reg_file[REG_AUTO_PLUGGED][0]) begin
                    active_flag = 1'b1;
                    r.notify_enabled = 1'b1;
                end
            end else if (plug_out) begin
                if (muted_by_us)
                    r.mute_write = 1'b1;
                muted_by_us = 1'b0;
            end
        end
        r.is_active = active_flag;
        return r;
    endfunction

    // Offer one tick; returns once taken, at times after a random gap if not steady.
    task automatic send_tick(logic [BTN_W-1:0] btn, bit present, bit muted,
                             bit power_valid, bit resuming, bit resume_done);
        tick_t        t;
        mute_result_t want;
        t = '{btn, present, muted, power_valid, resuming, resume_done};
        s_valid <= 1'b1;
        s_buttons <= btn;
        s_headphone_present <= present;
        s_current_muted <= muted;
        s_power_event_valid <= power_valid;
        s_power_resuming <= resuming;
        s_power_resume_done <= resume_done;
        do @(posedge aclk); while (!s_ready);
        want = predict_mute_action(t);
        expected_actions.push_back(want);
        ticks_sent++;
        if (want.mute_write)
            speaker_muted = want.mute_value;
        if (!steady && $urandom_range(0, 99) < 31) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge aclk);
        end
    endtask

    // Drop valid and wait until every result is back and the pipeline is empty.
    task automatic drain_results();
        s_valid <= 1'b0;
        wait (expected_actions.size() == 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(reg_index_t idx, logic [DATA_W-1:0] value);
        logic [DATA_W-1:0] width_mask;
        logic [DATA_W-1:0] readback;
        case (idx)
            REG_STARTUP_MODE: width_mask = 32'h3;
            REG_TOGGLE_MASK:  width_mask = '1;
            default:          width_mask = 32'h1;
        endcase
        reg_file[idx] = value & width_mask;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_W'(4 * int'(idx));
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        // read back right away, keep psel up
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        readback = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        // return to idle before the next transfer
        @(posedge aclk);
        if (readback !== reg_file[idx]) begin
            error_count++;
            $display("%0t ns: register %s readback, expected %h actual %h",
                     $time, idx.name(), reg_file[idx], readback);
        end
    endtask

    task automatic load_settings(logic [1:0] mode, logic [31:0] chord, bit notify,
                                 bit plugged, bit watch, bit resume_off);
        drain_results();
        write_reg(REG_STARTUP_MODE, DATA_W'(mode));
        write_reg(REG_TOGGLE_MASK, chord);
        write_reg(REG_NOTIFY_ENABLE, DATA_W'(notify));
        write_reg(REG_AUTO_PLUGGED, DATA_W'(plugged));
        write_reg(REG_RESUME_WATCH, DATA_W'(watch));
        write_reg(REG_RESUME_DISABLE, DATA_W'(resume_off));
        settings_loaded++;
    endtask

    // First tick applies the startup mode; holding the chord there as well can
    // raise both the enabled and the disabled message in one tick.
    task automatic test_startup();
        load_settings(2'($urandom_range(0, 3)), 32'h0000_0003, 1'b1, 1'b0, 1'b0, 1'b0);
        send_tick(32'h0000_0003, 1'($urandom_range(0, 1)), 1'b0, 1'b0, 1'b0, 1'b0);
        send_tick(32'h0000_0000, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
    endtask

    task automatic test_plug_edges();
        if (!active_flag) begin
            send_tick(32'h0000_0003, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
            send_tick(32'h0000_0000, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
        end
        send_tick(32'h0000_0000, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);  // unplug: mute
        send_tick(32'h0000_0000, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0);  // already muted
        send_tick(32'h0000_0000, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0);  // plug in: restore
        send_tick(32'h0000_0000, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        send_tick(32'h0000_0003, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0);  // toggle off unplugged
        send_tick(32'h0000_0000, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
    endtask

    task automatic test_toggle_chord();
        load_settings(MODE_ON, 32'h8000_0001, 1'b0, 1'b0, 1'b0, 1'b0);
        send_tick(32'h8000_0001, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
        send_tick(32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);  // still held
        send_tick(32'h8000_0000, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);  // partial: released
        send_tick(32'h8000_00F1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        send_tick(32'h0000_0000, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        // empty chord always matches: one toggle, then stuck waiting for release
        load_settings(MODE_OFF, 32'h0000_0000, 1'b1, 1'b1, 1'b0, 1'b0);
        send_tick(32'h0000_0000, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
        send_tick(32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
        send_tick(32'h0000_0000, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    endtask

    task automatic test_resume();
        load_settings(MODE_OFF, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b1, 1'b1);
        send_tick(32'h0000_0000, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0);  // resuming only
        send_tick(32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);  // still frozen
        send_tick(32'h0000_0000, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1);  // complete, plugged
        send_tick(32'h0000_0000, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        send_tick(32'h0000_0000, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1);  // complete, unplugged
        send_tick(32'h0000_0000, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0);
        load_settings(MODE_DETECT, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0, 1'b1);
        send_tick(32'h0000_0000, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0);  // ignored
    endtask

    // Receiver stops for a long stretch while ticks keep coming.
    task automatic test_output_stall();
        int i;
        steady = 1'b1;
        hold_req = 1'b1;
        for (i = 0; i < 40; i++)
            send_tick($urandom(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)));
        steady = 1'b0;
    endtask

    // Plausible traffic: slow plug changes, held chords, resume sequences.
    task automatic test_random_traffic(int count, bit calm, logic [1:0] mode,
                                       logic [31:0] chord, bit notify, bit plugged,
                                       bit watch, bit resume_off);
        int               i;
        int               pick;
        int               chord_left;
        bit               plugged_now;
        bit               pv;
        bit               pr;
        bit               pd;
        logic [BTN_W-1:0] btn;
        load_settings(mode, chord, notify, plugged, watch, resume_off);
        steady = calm;
        chord_left = 0;
        plugged_now = phones_seen;
        for (i = 0; i < count; i++) begin
            if ($urandom_range(0, 99) < 8)
                plugged_now = !plugged_now;
            if ($urandom_range(0, 99) < 5)
                speaker_muted = !speaker_muted;
            btn = $urandom();
            if (chord_left > 0) begin
                btn |= reg_file[REG_TOGGLE_MASK];
                chord_left--;
            end else begin
                if ($urandom_range(0, 1))
                    btn &= ~reg_file[REG_TOGGLE_MASK];
                if ($urandom_range(0, 99) < 10)
                    chord_left = $urandom_range(1, 4);
            end
            pick = $urandom_range(0, 99);
            pv = 1'b0;
            pr = 1'($urandom_range(0, 1));
            pd = 1'($urandom_range(0, 1));
            if (pick < 5) begin
                pv = 1'b1;
                pr = 1'b1;
                pd = 1'b0;
            end else if (pick < 9) begin
                pv = 1'b1;
                pd = 1'b1;
            end else if (pick < 11) begin
                pv = 1'b1;
            end
            send_tick(btn, plugged_now, speaker_muted, pv, pr, pd);
        end
        steady = 1'b0;
    endtask

    always @(posedge aclk) begin : result_monitor
        mute_result_t seen;
        mute_result_t want;
        if (m_valid && m_ready) begin
            seen = {m_mute_write, m_mute_value, m_is_active, m_notify_enabled,
                    m_notify_disabled, m_notify_muted, m_notify_clear, m_settle_delay};
            if (expected_actions.size() == 0) begin
                error_count++;
                $display("%0t ns: result transfer with none expected, expected none actual %b",
                         $time, seen);
            end else begin
                want = expected_actions.pop_front();
                results_checked++;
                for (int k = 0; k < $bits(mute_result_t); k++) begin
                    if (seen[k] !== want[k]) begin
                        error_count++;
                        $display("%0t ns: %s mismatch, expected %b actual %b",
                                 $time, result_field[k], want[k], seen[k]);
                    end
                end
            end
        end
        if (hold_req) begin
            hold_req = 1'b0;
            hold_left = HOLD_OFF_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (steady) begin
            m_ready <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= 31);
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || (psel && penable && pready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t ns: no transfer for %0d cycles", $time, STALL_LIMIT);
        $display("FAIL");
        $finish;
    end

    initial begin : run
        int          phase;
        logic [31:0] chord_pick;
        reg_file[REG_STARTUP_MODE] = MODE_DETECT;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        test_startup();
        test_plug_edges();
        test_toggle_chord();
        test_resume();
        test_output_stall();
        test_random_traffic(315, 1'b0, MODE_UNUSED, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 1'b1);
        test_random_traffic(315, 1'b0, MODE_OFF, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 1'b0);
        for (phase = 0; phase < 4; phase++) begin
            case ($urandom_range(0, 3))
                0:       chord_pick = '0;
                1:       chord_pick = 32'h1 << $urandom_range(0, 31);
                2:       chord_pick = $urandom() & $urandom();
                default: chord_pick = $urandom() | $urandom();
            endcase
            test_random_traffic(315, phase == 1, 2'($urandom_range(0, 3)), chord_pick,
                                1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end
        drain_results();
        $display("Sent %0d poll ticks under %0d register settings: startup, plug edges,",
                 ticks_sent, settings_loaded);
        $display("chord toggle, resume and output stall; %0d results compared, %0d errors",
                 results_checked, error_count);
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+design
design/hamc_pkg.sv
design/headphone_auto_mute_controller_core.sv
tb/headphone_auto_mute_controller_core_tb.sv
